FILE: rtl/bbsa_pkg.sv
// Shared field widths, request and status codes, and the bit-scan result type.
`default_nettype none
package bbsa_pkg;

	localparam int KIND_W  = 3;
	localparam int BSEL_W  = 4;
	localparam int SLOT_W  = 6;
	localparam int STAT_W  = 3;
	localparam int TOTAL_W = 11;

	localparam logic [KIND_W-1:0] KIND_ALLOC  = 3'd0;
	localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd1;
	localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_GET    = 3'd3;
	localparam logic [KIND_W-1:0] KIND_NEXT   = 3'd4;

	localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
	localparam logic [STAT_W-1:0] ST_NOSPACE = 3'd1;
	localparam logic [STAT_W-1:0] ST_NOTOCC  = 3'd2;
	localparam logic [STAT_W-1:0] ST_BADBKT  = 3'd3;
	localparam logic [STAT_W-1:0] ST_NONE    = 3'd4;

	typedef struct packed {
		logic              found;
		logic [SLOT_W-1:0] idx;
	} scan_res_t;

endpackage
`default_nettype wire

FILE: rtl/bbsa_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module bbsa_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  wire logic                                         clk,
	input  wire logic                                         we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                             wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                             rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

FILE: rtl/bbsa_scan.sv
// Two-step lowest-set-bit finder: byte group first, then the bit within it.
`default_nettype none
module bbsa_scan #(
	parameter int WIDTH = 64
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [WIDTH-1:0] vec,
	output bbsa_pkg::scan_res_t   res
);
	import bbsa_pkg::*;

	localparam int NG = (WIDTH + 7) / 8;
	localparam int PW = NG * 8;

	logic [PW-1:0] pad;
	logic [NG-1:0] grp_any;
	logic [2:0]    grp_sel;
	logic [7:0]    grp_byte;
	logic          found_s1;
	logic [2:0]    grp_s1;
	logic [7:0]    byte_s1;
	logic [2:0]    bit_sel;

	assign pad = PW'(vec);

	// Scanning from the top down leaves the lowest nonzero group selected.
	always_comb begin
		grp_sel  = '0;
		grp_byte = '0;
		for (int g = NG - 1; g >= 0; g--) begin
			grp_any[g] = |pad[g*8 +: 8];
			if (grp_any[g]) begin
				grp_sel  = 3'(g);
				grp_byte = pad[g*8 +: 8];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_s1 <= 1'b0;
			grp_s1   <= '0;
			byte_s1  <= '0;
		end else if (start) begin
			found_s1 <= |grp_any;
			grp_s1   <= grp_sel;
			byte_s1  <= grp_byte;
		end
	end

	always_comb begin
		bit_sel = '0;
		for (int b = 7; b >= 0; b--) begin
			if (byte_s1[b]) begin
				bit_sel = 3'(b);
			end
		end
		res.found = found_s1;
		res.idx   = {grp_s1, bit_sel};
	end
endmodule
`default_nettype wire

FILE: rtl/bitmap_bucket_slot_allocator.sv
// Get and remove read one bucket map; allocate scans the head bucket for a free slot,
// next scans bucket after bucket, and remove-all visits every open bucket in turn.
// One request is in flight at a time; the next input beat is taken the cycle after
// the result is loaded.
// arst_n clears all control state; the first cycle after reset writes an empty map
// to bucket zero, and s_tready stays low during that cycle.
`default_nettype none
module bitmap_bucket_slot_allocator #(
	parameter int SLOTS_PER_BUCKET = 64,
	parameter int MAX_BUCKETS      = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,  // bucket_sel[3:0], slot_sel[9:4], zero[15:10]
	input  wire logic [2:0]  s_tuser,  // kind[2:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [31:0] m_tdata   // status[2:0], out_bucket[6:3], out_slot[12:7],
	                                   // occupied[13], total_items[24:14], zero[31:25]
);
	import bbsa_pkg::*;

	localparam int BKT_W = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
	localparam int CW    = $clog2(MAX_BUCKETS + 1);
	localparam int XW    = (CW > BSEL_W) ? CW : BSEL_W;
	localparam int SIW   = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
	localparam logic [SLOTS_PER_BUCKET-1:0] SLOT_MASK = '1;

	typedef enum logic [15:0] {
		S_INIT     = 16'h0001,
		S_IDLE     = 16'h0002,
		S_ALC_RD   = 16'h0004,
		S_ALC_SCAN = 16'h0008,
		S_ALC_WR   = 16'h0010,
		S_ALC_POP  = 16'h0020,
		S_REM_RD   = 16'h0040,
		S_REM_WR   = 16'h0080,
		S_CLR_RD   = 16'h0100,
		S_CLR_WR   = 16'h0200,
		S_GET_RD   = 16'h0400,
		S_GET_CHK  = 16'h0800,
		S_NXT_RD   = 16'h1000,
		S_NXT_SCAN = 16'h2000,
		S_NXT_RES  = 16'h4000,
		S_RESP     = 16'h8000
	} state_t;

	state_t state_q;

	logic [BSEL_W-1:0]  bsel_q;
	logic [SLOT_W-1:0]  ssel_q;
	logic [CW-1:0]      open_q;
	logic [CW-1:0]      len_q;
	logic [BKT_W-1:0]   head_q;
	logic [TOTAL_W-1:0] total_q;
	logic [BKT_W-1:0]   cur_b_q;
	logic               fresh_q;
	logic               first_q;
	logic [SLOTS_PER_BUCKET-1:0] map_q;
	logic [STAT_W-1:0]  res_status_q;
	logic [BSEL_W-1:0]  res_bucket_q;
	logic [SLOT_W-1:0]  res_slot_q;
	logic               res_occ_q;
	logic               m_tvalid_q;
	logic [31:0]        m_tdata_q;

	logic [KIND_W-1:0]  in_kind;
	logic [BSEL_W-1:0]  in_bsel;
	logic [SLOT_W-1:0]  in_ssel;
	logic               in_bad;

	logic                        map_we;
	logic [BKT_W-1:0]            map_waddr;
	logic [SLOTS_PER_BUCKET-1:0] map_wdata;
	logic [SLOTS_PER_BUCKET-1:0] map_rd;
	logic                        lst_we;
	logic [BKT_W-1:0]            lst_waddr;
	logic [BKT_W-1:0]            lst_raddr;
	logic [BKT_W-1:0]            lst_rdata;
	logic [CW-1:0]               len_m1;

	logic                        scan_start;
	logic [SLOTS_PER_BUCKET-1:0] scan_vec;
	scan_res_t                   scan_res;

	logic [SLOTS_PER_BUCKET-1:0] sel_onehot;
	logic [SLOTS_PER_BUCKET-1:0] idx_onehot;
	logic [SLOTS_PER_BUCKET-1:0] gt_mask;
	logic                        slot_in_range;
	logic                        sel_bit;
	logic                        rd_full;
	logic                        alc_full;
	logic                        can_push;
	logic                        last_bkt;
	logic                        out_free;

	assign in_kind = s_tuser[KIND_W-1:0];
	assign in_bsel = s_tdata[BSEL_W-1:0];
	assign in_ssel = s_tdata[BSEL_W +: SLOT_W];
	assign in_bad  = XW'(in_bsel) >= XW'(open_q);

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign out_free = !m_tvalid_q || m_tready;

	bbsa_ram #(
		.WIDTH(SLOTS_PER_BUCKET),
		.DEPTH(MAX_BUCKETS)
	) u_map_ram (
		.clk  (clk),
		.we   (map_we),
		.waddr(map_waddr),
		.wdata(map_wdata),
		.raddr(cur_b_q),
		.rdata(map_rd)
	);

	// Entry zero of the not-full list lives in head_q; the RAM holds the rest.
	bbsa_ram #(
		.WIDTH(BKT_W),
		.DEPTH(MAX_BUCKETS)
	) u_list_ram (
		.clk  (clk),
		.we   (lst_we),
		.waddr(lst_waddr),
		.wdata(cur_b_q),
		.raddr(lst_raddr),
		.rdata(lst_rdata)
	);

	bbsa_scan #(
		.WIDTH(SLOTS_PER_BUCKET)
	) u_scan (
		.clk   (clk),
		.arst_n(arst_n),
		.start (scan_start),
		.vec   (scan_vec),
		.res   (scan_res)
	);

	always_comb begin
		for (int j = 0; j < SLOTS_PER_BUCKET; j++) begin
			sel_onehot[j] = (ssel_q == SLOT_W'(j));
			idx_onehot[j] = (scan_res.idx == SLOT_W'(j));
			gt_mask[j]    = (SLOT_W'(j) > ssel_q);
		end
	end

	assign slot_in_range = (SLOT_W+1)'(ssel_q) < (SLOT_W+1)'(SLOTS_PER_BUCKET);
	assign sel_bit       = slot_in_range && map_rd[ssel_q[SIW-1:0]];
	assign rd_full       = (map_rd == SLOT_MASK);
	assign alc_full      = ((map_q | idx_onehot) == SLOT_MASK);
	assign can_push      = len_q < CW'(MAX_BUCKETS);
	assign last_bkt      = (CW'(cur_b_q) + CW'(1)) >= open_q;
	assign len_m1        = len_q - CW'(1);
	assign lst_raddr     = len_m1[BKT_W-1:0];
	assign lst_waddr     = len_q[BKT_W-1:0];

	always_comb begin
		map_we     = 1'b0;
		map_waddr  = cur_b_q;
		map_wdata  = '0;
		lst_we     = 1'b0;
		scan_start = 1'b0;
		scan_vec   = '0;
		case (state_q)
			S_INIT: begin
				map_we    = 1'b1;
				map_waddr = '0;
			end
			S_ALC_SCAN: begin
				scan_start = 1'b1;
				scan_vec   = fresh_q ? SLOT_MASK : ~map_rd;
			end
			S_ALC_WR: begin
				map_we    = scan_res.found;
				map_wdata = map_q | idx_onehot;
			end
			S_REM_WR: begin
				map_we    = sel_bit;
				map_wdata = map_rd & ~sel_onehot;
				lst_we    = sel_bit && rd_full && can_push && (len_q != '0);
			end
			S_CLR_WR: begin
				map_we = 1'b1;
				lst_we = rd_full && can_push && (len_q != '0);
			end
			S_NXT_SCAN: begin
				scan_start = 1'b1;
				scan_vec   = first_q ? (map_rd & gt_mask) : map_rd;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_INIT;
			bsel_q       <= '0;
			ssel_q       <= '0;
			open_q       <= CW'(1);
			len_q        <= CW'(1);
			head_q       <= '0;
			total_q      <= '0;
			cur_b_q      <= '0;
			fresh_q      <= 1'b0;
			first_q      <= 1'b0;
			map_q        <= '0;
			res_status_q <= ST_OK;
			res_bucket_q <= '0;
			res_slot_q   <= '0;
			res_occ_q    <= 1'b0;
			m_tvalid_q   <= 1'b0;
			m_tdata_q    <= '0;
		end else begin
			if (state_q == S_RESP && out_free) begin
				m_tvalid_q <= 1'b1;
				m_tdata_q  <= 32'({total_q, res_occ_q, res_slot_q, res_bucket_q, res_status_q});
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			case (state_q)
				S_INIT: begin
					state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (s_tvalid) begin
						bsel_q       <= in_bsel;
						ssel_q       <= in_ssel;
						res_status_q <= ST_OK;
						res_bucket_q <= '0;
						res_slot_q   <= '0;
						res_occ_q    <= 1'b0;
						fresh_q      <= 1'b0;
						first_q      <= 1'b1;
						cur_b_q      <= BKT_W'(in_bsel);
						state_q      <= S_RESP;
						case (in_kind)
							KIND_ALLOC: begin
								if (len_q != '0) begin
									cur_b_q <= head_q;
									state_q <= S_ALC_RD;
								end else if (open_q < CW'(MAX_BUCKETS)) begin
									// A newly opened bucket is empty, so its map is not read.
									cur_b_q <= open_q[BKT_W-1:0];
									head_q  <= open_q[BKT_W-1:0];
									open_q  <= open_q + CW'(1);
									len_q   <= CW'(1);
									fresh_q <= 1'b1;
									state_q <= S_ALC_SCAN;
								end else begin
									res_status_q <= ST_NOSPACE;
								end
							end
							KIND_REMOVE: begin
								if (in_bad) res_status_q <= ST_BADBKT;
								else state_q <= S_REM_RD;
							end
							KIND_CLEAR: begin
								cur_b_q <= '0;
								state_q <= S_CLR_RD;
							end
							KIND_GET: begin
								if (in_bad) res_status_q <= ST_BADBKT;
								else state_q <= S_GET_RD;
							end
							KIND_NEXT: begin
								if (in_bad) res_status_q <= ST_BADBKT;
								else state_q <= S_NXT_RD;
							end
							default: begin
							end
						endcase
					end
				end
				S_ALC_RD: begin
					state_q <= S_ALC_SCAN;
				end
				S_ALC_SCAN: begin
					map_q   <= fresh_q ? '0 : map_rd;
					state_q <= S_ALC_WR;
				end
				S_ALC_WR: begin
					state_q <= S_RESP;
					if (!scan_res.found) begin
						res_status_q <= ST_NOSPACE;
					end else begin
						total_q      <= total_q + TOTAL_W'(1);
						res_bucket_q <= BSEL_W'(cur_b_q);
						res_slot_q   <= scan_res.idx;
						if (alc_full) begin
							// The full bucket leaves the list; the tail entry moves to the head.
							len_q <= len_m1;
							if (len_q > CW'(1)) state_q <= S_ALC_POP;
						end
					end
				end
				S_ALC_POP: begin
					head_q  <= lst_rdata;
					state_q <= S_RESP;
				end
				S_REM_RD: begin
					state_q <= S_REM_WR;
				end
				S_REM_WR: begin
					if (!sel_bit) begin
						res_status_q <= ST_NOTOCC;
					end else begin
						total_q <= total_q - TOTAL_W'(1);
						if (rd_full && can_push) begin
							if (len_q == '0) head_q <= cur_b_q;
							len_q <= len_q + CW'(1);
						end
					end
					state_q <= S_RESP;
				end
				S_CLR_RD: begin
					state_q <= S_CLR_WR;
				end
				S_CLR_WR: begin
					if (rd_full && can_push) begin
						if (len_q == '0) head_q <= cur_b_q;
						len_q <= len_q + CW'(1);
					end
					if (last_bkt) begin
						total_q <= '0;
						state_q <= S_RESP;
					end else begin
						cur_b_q <= cur_b_q + BKT_W'(1);
						state_q <= S_CLR_RD;
					end
				end
				S_GET_RD: begin
					state_q <= S_GET_CHK;
				end
				S_GET_CHK: begin
					res_bucket_q <= bsel_q;
					res_slot_q   <= ssel_q;
					res_occ_q    <= sel_bit;
					state_q      <= S_RESP;
				end
				S_NXT_RD: begin
					state_q <= S_NXT_SCAN;
				end
				S_NXT_SCAN: begin
					state_q <= S_NXT_RES;
				end
				S_NXT_RES: begin
					if (scan_res.found) begin
						res_bucket_q <= BSEL_W'(cur_b_q);
						res_slot_q   <= scan_res.idx;
						res_occ_q    <= 1'b1;
						state_q      <= S_RESP;
					end else if (last_bkt) begin
						res_status_q <= ST_NONE;
						state_q      <= S_RESP;
					end else begin
						cur_b_q <= cur_b_q + BKT_W'(1);
						first_q <= 1'b0;
						state_q <= S_NXT_RD;
					end
				end
				S_RESP: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule
`default_nettype wire

FILE: rtl/bbsa_checker.sv
// Port-level checks for the slot allocator, bound to its top level.
`default_nettype none
module bbsa_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic [15:0] s_tdata,
	input wire logic [2:0]  s_tuser,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [31:0] m_tdata
);
	import bbsa_pkg::*;

	logic [STAT_W-1:0] st;
	assign st = m_tdata[STAT_W-1:0];

	// A held result beat keeps its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	// Every accepted request moves the block out of idle, so the input closes after a beat.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted on back-to-back cycles");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (st == ST_OK || st == ST_NOSPACE || st == ST_NOTOCC ||
			st == ST_BADBKT || st == ST_NONE))
		else $error("undefined status code");

	// An error result carries no bucket, slot or occupied flag.
	a_error_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && st != ST_OK |-> m_tdata[13:3] == '0)
		else $error("error result with nonzero location");

	logic unused_in;
	assign unused_in = ^{s_tdata, s_tuser};
endmodule

bind bitmap_bucket_slot_allocator bbsa_checker u_bbsa_checker (.*);
`default_nettype wire

FILE: verif/testbench.sv
// Self-checking testbench for the bucket slot allocator with a queue-based predictor.
`timescale 1ns / 1ps

import bbsa_pkg::*;

typedef struct packed {
	logic [6:0]         pad;
	logic [TOTAL_W-1:0] total;
	logic               occ;
	logic [SLOT_W-1:0]  slot;
	logic [BSEL_W-1:0]  bucket;
	logic [STAT_W-1:0]  status;
} answer_t;

class alloc_tracker;
	localparam int NUM_BUCKETS = 16;
	localparam int BUCKET_SLOTS = 64;

	logic [63:0]        occ_map [NUM_BUCKETS];
	logic [6:0]         fill [NUM_BUCKETS];
	logic [4:0]         open_cnt;
	logic [BSEL_W-1:0]  free_list [NUM_BUCKETS];
	logic [4:0]         free_len;
	logic [TOTAL_W-1:0] total;
	answer_t            answers_due [$];
	int                 errors;

	function new();
		for (int i = 0; i < NUM_BUCKETS; i++) begin
			occ_map[i] = '0;
			fill[i] = '0;
			free_list[i] = '0;
		end
		open_cnt = 5'd1;
		free_len = 5'd1;
		total = '0;
		errors = 0;
	endfunction

	function int lowest_set(logic [63:0] v);
		for (int i = 0; i < 64; i++)
			if (v[i])
				return i;
		return -1;
	endfunction

	function bit all_full();
		return free_len == 0 && open_cnt == NUM_BUCKETS;
	endfunction

	function int pending();
		return answers_due.size();
	endfunction

	function int open_buckets();
		return open_cnt;
	endfunction

	// Picks an occupied slot at random, so removes hit real items.
	function bit pick_occupied(output logic [BSEL_W-1:0] b, output logic [SLOT_W-1:0] s);
		int start;
		int bi;
		int si;
		b = '0;
		s = '0;
		if (total == 0)
			return 0;
		start = $urandom_range(open_cnt - 1);
		for (int i = 0; i < open_cnt; i++) begin
			bi = (start + i) % open_cnt;
			if (occ_map[bi] != 0) begin
				start = $urandom_range(63);
				for (int j = 0; j < 64; j++) begin
					si = (start + j) % 64;
					if (occ_map[bi][si]) begin
						b = bi[BSEL_W-1:0];
						s = si[SLOT_W-1:0];
						return 1;
					end
				end
			end
		end
		return 0;
	endfunction

	function void take_request(logic [KIND_W-1:0] kind, logic [BSEL_W-1:0] b,
	                           logic [SLOT_W-1:0] s);
		answer_t ans;
		bit ok;
		bit was_full;
		bit found;
		logic [BSEL_W-1:0] hb;
		logic [63:0] rest;
		int pos;
		ans = '0;
		case (kind)
			KIND_ALLOC: begin
				ok = 1;
				if (free_len == 0) begin
					if (open_cnt < NUM_BUCKETS) begin
						hb = open_cnt[BSEL_W-1:0];
						occ_map[hb] = '0;
						fill[hb] = '0;
						open_cnt++;
						free_list[0] = hb;
						free_len = 5'd1;
					end else begin
						ok = 0;
					end
				end
				if (ok) begin
					hb = free_list[0];
					pos = lowest_set(~occ_map[hb]);
					if (pos < 0) begin
						ok = 0;
					end else begin
						occ_map[hb][pos] = 1'b1;
						fill[hb]++;
						total++;
						// A bucket that just filled leaves the list; the tail entry takes its place.
						if (fill[hb] >= BUCKET_SLOTS) begin
							free_list[0] = free_list[free_len[BSEL_W-1:0] - BSEL_W'(1)];
							free_len--;
						end
						ans.bucket = hb;
						ans.slot = pos[SLOT_W-1:0];
					end
				end
				if (!ok)
					ans.status = ST_NOSPACE;
			end
			KIND_REMOVE: begin
				if ({1'b0, b} >= open_cnt) begin
					ans.status = ST_BADBKT;
				end else if (!occ_map[b][s]) begin
					ans.status = ST_NOTOCC;
				end else begin
					was_full = fill[b] == BUCKET_SLOTS;
					occ_map[b][s] = 1'b0;
					fill[b]--;
					total--;
					if (was_full && free_len < NUM_BUCKETS) begin
						free_list[free_len[BSEL_W-1:0]] = b;
						free_len++;
					end
				end
			end
			KIND_CLEAR: begin
				for (int i = 0; i < open_cnt; i++) begin
					was_full = fill[i] == BUCKET_SLOTS;
					occ_map[i] = '0;
					fill[i] = '0;
					if (was_full && free_len < NUM_BUCKETS) begin
						free_list[free_len[BSEL_W-1:0]] = i[BSEL_W-1:0];
						free_len++;
					end
				end
				total = '0;
			end
			KIND_GET: begin
				if ({1'b0, b} >= open_cnt) begin
					ans.status = ST_BADBKT;
				end else begin
					ans.bucket = b;
					ans.slot = s;
					ans.occ = occ_map[b][s];
				end
			end
			KIND_NEXT: begin
				if ({1'b0, b} >= open_cnt) begin
					ans.status = ST_BADBKT;
				end else begin
					found = 0;
					rest = '0;
					if (s < 63)
						rest = occ_map[b] & ~((64'd2 << s) - 64'd1);
					if (rest != 0) begin
						found = 1;
						ans.bucket = b;
						ans.slot = SLOT_W'(lowest_set(rest));
					end else begin
						for (int i = b + 1; i < open_cnt; i++) begin
							if (!found && occ_map[i] != 0) begin
								found = 1;
								ans.bucket = i[BSEL_W-1:0];
								ans.slot = SLOT_W'(lowest_set(occ_map[i]));
							end
						end
					end
					if (found)
						ans.occ = 1'b1;
					else
						ans.status = ST_NONE;
				end
			end
			default: begin
			end
		endcase
		ans.total = total;
		answers_due.push_back(ans);
	endfunction

	function void compare_field(string name, int want, int got);
		if (want != got) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			errors++;
		end
	endfunction

	function void check_answer(logic [31:0] beat);
		answer_t want;
		answer_t got;
		got = beat;
		if (answers_due.size() == 0) begin
			$display("%0t: result beat %h expected nothing, got a beat", $time, beat);
			errors++;
			return;
		end
		want = answers_due.pop_front();
		compare_field("status", want.status, got.status);
		compare_field("out_bucket", want.bucket, got.bucket);
		compare_field("out_slot", want.slot, got.slot);
		compare_field("occupied", want.occ, got.occ);
		compare_field("total_items", want.total, got.total);
		compare_field("padding", want.pad, got.pad);
	endfunction
endclass

module testbench;
	localparam int CYCLE_LIMIT = 400000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;   // bucket_sel[3:0], slot_sel[9:4], zero[15:10]
	logic [2:0]  s_tuser = '0;   // kind[2:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;        // status[2:0], out_bucket[6:3], out_slot[12:7],
	                             // occupied[13], total_items[24:14], zero[31:25]

	alloc_tracker tracker = new();
	bit calm = 0;
	int cycles = 0;

	bitmap_bucket_slot_allocator uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			tracker.check_answer(m_tdata);
		m_tready <= calm || ($urandom_range(99) >= 21);
	end

	// Valid is only lowered during an idle gap, so back-to-back beats keep it high.
	task automatic send_req(input logic [KIND_W-1:0] kind, input logic [BSEL_W-1:0] b,
	                        input logic [SLOT_W-1:0] s);
		while (!calm && $urandom_range(99) < 21) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {6'd0, s, b};
		s_tuser <= kind;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		tracker.take_request(kind, b, s);
	endtask

	task automatic one_random(input int w_alloc, input int w_rem, input int w_clear);
		int r;
		int sub;
		logic [BSEL_W-1:0] b;
		logic [SLOT_W-1:0] s;
		r = $urandom_range(99);
		if ($urandom_range(3) == 0)
			b = BSEL_W'($urandom_range(15));
		else
			b = BSEL_W'($urandom_range(tracker.open_buckets() - 1));
		s = SLOT_W'($urandom_range(63));
		if (r < w_alloc) begin
			send_req(KIND_ALLOC, BSEL_W'($urandom_range(15)), SLOT_W'($urandom_range(63)));
		end else if (r < w_alloc + w_rem) begin
			if (!tracker.pick_occupied(b, s))
				s = SLOT_W'($urandom_range(63));
			send_req(KIND_REMOVE, b, s);
		end else if (r < w_alloc + w_rem + w_clear) begin
			send_req(KIND_CLEAR, b, s);
		end else begin
			sub = $urandom_range(9);
			if (sub < 4)
				send_req(KIND_GET, b, s);
			else if (sub < 8)
				send_req(KIND_NEXT, b, s);
			else
				send_req(KIND_W'($urandom_range(7)), BSEL_W'($urandom_range(15)),
				         SLOT_W'($urandom_range(63)));
		end
	endtask

	initial begin
		int n;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: empty state, bad buckets, unused kinds, refill of a freed low slot.
		send_req(KIND_GET, 4'd0, 6'd0);
		send_req(KIND_GET, 4'd1, 6'd5);
		send_req(KIND_NEXT, 4'd0, 6'd0);
		send_req(KIND_REMOVE, 4'd0, 6'd0);
		send_req(KIND_REMOVE, 4'd15, 6'd63);
		send_req(KIND_NEXT, 4'd15, 6'd63);
		send_req(3'd5, 4'd15, 6'd63);
		send_req(3'd6, 4'd0, 6'd0);
		send_req(3'd7, 4'd10, 6'd42);
		send_req(KIND_ALLOC, 4'd0, 6'd0);
		send_req(KIND_ALLOC, 4'd15, 6'd63);
		send_req(KIND_ALLOC, 4'd0, 6'd0);
		send_req(KIND_GET, 4'd0, 6'd1);
		send_req(KIND_GET, 4'd0, 6'd63);
		send_req(KIND_NEXT, 4'd0, 6'd0);
		send_req(KIND_NEXT, 4'd0, 6'd63);
		send_req(KIND_REMOVE, 4'd0, 6'd1);
		send_req(KIND_REMOVE, 4'd0, 6'd1);
		// The freed slot 1 must be reused, not the slot at the fill count.
		send_req(KIND_ALLOC, 4'd0, 6'd0);
		send_req(KIND_GET, 4'd0, 6'd2);
		send_req(KIND_CLEAR, 4'd0, 6'd0);
		send_req(KIND_GET, 4'd0, 6'd0);
		send_req(KIND_NEXT, 4'd0, 6'd0);

		// Fill every bucket, or stop after 1600 requests, with a few removes so full buckets rejoin the list.
		n = 0;
		while (!tracker.all_full() && n < 1600) begin
			calm = (n >= 200 && n < 500);
			one_random(90, 4, 0);
			n++;
		end
		calm = 0;
		repeat (12)
			one_random(70, 10, 0);
		repeat (60)
			one_random(30, 50, 0);
		send_req(KIND_CLEAR, BSEL_W'($urandom_range(15)), SLOT_W'($urandom_range(63)));
		repeat (120)
			one_random(35, 25, 3);

		@(posedge clk);
		s_tvalid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (tracker.errors == 0 && tracker.pending() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule

FILE: bitmap_bucket_slot_allocator.f
rtl/bbsa_pkg.sv
rtl/bbsa_ram.sv
rtl/bbsa_scan.sv
rtl/bitmap_bucket_slot_allocator.sv
rtl/bbsa_checker.sv
verif/testbench.sv
